[rtl/ljpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ljpf_pkg;

  localparam int COORD_W    = 32;
  localparam int CELL_W     = 31;
  localparam int CUT_W      = 32;
  localparam int OUT_W      = 48;
  localparam int D2_W       = 64;
  localparam int INV2_W     = 47;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // minimum-image remainder unit
  localparam int WR_MAG_W = 36;
  localparam int WR_REM_W = 32;
  localparam int WR_STEP  = 4;
  localparam int WR_STG   = 9;

  // reciprocal unit: 48 quotient steps
  localparam int RC_STEP = 4;
  localparam int RC_STG  = 12;

  // wide multiplier
  localparam int MUL_A_W  = 96;
  localparam int MUL_B_W  = 64;
  localparam int MUL_P_W  = 160;
  localparam int MUL_LIMB = 32;

  localparam int PIPE_LAT = 50;

  localparam logic [D2_W-1:0]  NEAR_LIMIT   = 64'h40_0000_0000;
  localparam logic [D2_W-1:0]  RC_REM_INIT  = 64'h10_0000_0000;
  localparam logic [OUT_W-1:0] POS_MAX      = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_MIN      = 48'h8000_0000_0000;
  localparam logic [62:0]      ENERGY_CLAMP = 63'h4_0000_0000_0000;

  localparam logic [CELL_W-1:0] RST_CELL      = 31'd41943040;
  localparam logic [CUT_W-1:0]  RST_CUTOFF_SQ = 32'd26214400;
  localparam logic [OUT_W-1:0]  RST_E_SHIFT   = 48'hFFFF_FFFB_D2A8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_X,
    CFG_CELL_Y,
    CFG_CELL_Z,
    CFG_CUTOFF_SQ,
    CFG_ENERGY_SHIFT
  } cfg_idx_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } lane_t;

  // signed saturation of a sign and magnitude pair to 48 bits
  function automatic logic [OUT_W-1:0] sat48(input logic neg, input logic [127:0] mag);
    logic [OUT_W-1:0] res;
    if (neg) begin
      if (mag > 128'h8000_0000_0000) res = NEG_MIN;
      else res = OUT_W'(-mag[OUT_W-1:0]);
    end else begin
      if (mag > 128'h7FFF_FFFF_FFFF) res = POS_MAX;
      else res = mag[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/ljpf_wrap.sv]
`timescale 1ns / 1ps
`default_nettype none
module ljpf_wrap (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ljpf_pkg::COORD_W-1:0] d,
  input  logic        [ljpf_pkg::CELL_W-1:0]  cell_len,
  output logic signed [ljpf_pkg::COORD_W-1:0] w
);
  import ljpf_pkg::*;

  logic        [WR_MAG_W-1:0] mag_r   [0:WR_STG];
  logic        [WR_REM_W-1:0] rem_r   [0:WR_STG];
  logic                       neg_r   [0:WR_STG];
  logic signed [COORD_W-1:0]  d_r     [0:WR_STG];
  logic        [WR_MAG_W-1:0] mag_nxt [1:WR_STG];
  logic        [WR_REM_W-1:0] rem_nxt [1:WR_STG];

  logic [33:0]          num;
  logic [33:0]          num_abs;
  logic [WR_REM_W-1:0]  den;
  logic [WR_MAG_W-1:0]  m_c;
  logic [WR_REM_W-1:0]  r_c;
  logic [WR_REM_W:0]    t_c;
  logic [WR_REM_W-1:0]  rmod;
  logic [WR_REM_W:0]    cent;
  logic signed [COORD_W-1:0] w_r;

  // floor remainder of (2d + c) by 2c; the wrapped value is (rem - c) / 2
  assign den     = {cell_len, 1'b0};
  assign num     = {d[COORD_W-1], d, 1'b0} + {3'b000, cell_len};
  assign num_abs = num[33] ? 34'(-num) : num;

  always_comb begin
    m_c = '0;
    r_c = '0;
    t_c = '0;
    for (int s = 1; s <= WR_STG; s++) begin
      m_c = mag_r[s-1];
      r_c = rem_r[s-1];
      for (int j = 0; j < WR_STEP; j++) begin
        t_c = {r_c, m_c[WR_MAG_W-1]};
        m_c = {m_c[WR_MAG_W-2:0], 1'b0};
        if (t_c >= {1'b0, den}) r_c = WR_REM_W'(t_c - {1'b0, den});
        else r_c = t_c[WR_REM_W-1:0];
      end
      mag_nxt[s] = m_c;
      rem_nxt[s] = r_c;
    end
  end

  assign rmod = (neg_r[WR_STG] && rem_r[WR_STG] != '0) ? den - rem_r[WR_STG] : rem_r[WR_STG];
  assign cent = {1'b0, rmod} - {2'b00, cell_len};

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= {2'b00, num_abs};
      rem_r[0] <= '0;
      neg_r[0] <= num[33];
      d_r[0]   <= d;
      for (int s = 1; s <= WR_STG; s++) begin
        mag_r[s] <= mag_nxt[s];
        rem_r[s] <= rem_nxt[s];
        neg_r[s] <= neg_r[s-1];
        d_r[s]   <= d_r[s-1];
      end
      // a zero cell leaves the component as it is
      w_r <= (cell_len == '0) ? d_r[WR_STG] : signed'(cent[WR_REM_W:1]);
    end
  end

  assign w = w_r;

endmodule
`default_nettype wire

[rtl/ljpf_recip.sv]
`timescale 1ns / 1ps
`default_nettype none
module ljpf_recip (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ljpf_pkg::D2_W-1:0]     d2,
  output logic [ljpf_pkg::INV2_W-1:0]   inv2
);
  import ljpf_pkg::*;

  // floor(2^84 / r); quotient bits above 46 are always zero, so start at bit 47
  logic [D2_W-1:0]   r_r     [0:RC_STG];
  logic [D2_W-1:0]   rem_r   [0:RC_STG];
  logic [INV2_W-1:0] q_r     [0:RC_STG];
  logic [D2_W-1:0]   rem_nxt [1:RC_STG];
  logic [INV2_W-1:0] q_nxt   [1:RC_STG];

  logic [D2_W-1:0]   r_c;
  logic [INV2_W-1:0] q_c;
  logic [D2_W:0]     t_c;

  always_comb begin
    r_c = '0;
    q_c = '0;
    t_c = '0;
    for (int s = 1; s <= RC_STG; s++) begin
      r_c = rem_r[s-1];
      q_c = q_r[s-1];
      for (int j = 0; j < RC_STEP; j++) begin
        t_c = {r_c, 1'b0};
        if (t_c >= {1'b0, r_r[s-1]}) begin
          r_c = D2_W'(t_c - {1'b0, r_r[s-1]});
          q_c = {q_c[INV2_W-2:0], 1'b1};
        end else begin
          r_c = t_c[D2_W-1:0];
          q_c = {q_c[INV2_W-2:0], 1'b0};
        end
      end
      rem_nxt[s] = r_c;
      q_nxt[s]   = q_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // very close pairs are overridden later; keep the divisor in range
      r_r[0]   <= (d2 < NEAR_LIMIT) ? NEAR_LIMIT : d2;
      rem_r[0] <= RC_REM_INIT;
      q_r[0]   <= '0;
      for (int s = 1; s <= RC_STG; s++) begin
        r_r[s]   <= r_r[s-1];
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  assign inv2 = q_r[RC_STG];

endmodule
`default_nettype wire

[rtl/ljpf_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module ljpf_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ljpf_pkg::MUL_A_W-1:0]   a,
  input  logic [ljpf_pkg::MUL_B_W-1:0]   b,
  output logic [ljpf_pkg::MUL_P_W-1:0]   p
);
  import ljpf_pkg::*;

  localparam int NA    = MUL_A_W / MUL_LIMB;
  localparam int NB    = MUL_B_W / MUL_LIMB;
  localparam int ROW_W = MUL_A_W + MUL_LIMB;

  logic [MUL_A_W-1:0]    a_r;
  logic [MUL_B_W-1:0]    b_r;
  logic [2*MUL_LIMB-1:0] pp_r  [0:NA-1][0:NB-1];
  logic [ROW_W-1:0]      row_r [0:NB-1];
  logic [ROW_W-1:0]      row_nxt [0:NB-1];
  logic [MUL_P_W-1:0]    p_nxt;

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_nxt[j] = row_nxt[j] + (ROW_W'(pp_r[i][j]) << (MUL_LIMB * i));
      end
    end
  end

  // limb products, then one row per b limb, then the final sum
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a;
      b_r <= b;
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= (2*MUL_LIMB)'(a_r[MUL_LIMB*i +: MUL_LIMB])
                        * (2*MUL_LIMB)'(b_r[MUL_LIMB*j +: MUL_LIMB]);
        end
      end
      for (int j = 0; j < NB; j++) row_r[j] <= row_nxt[j];
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int j = 0; j < NB; j++) begin
      p_nxt = p_nxt + (MUL_P_W'(row_r[j]) << (MUL_LIMB * j));
    end
  end

  logic [MUL_P_W-1:0] p_q_r;
  always_ff @(posedge clk) begin
    if (en) p_q_r <= p_nxt;
  end

  assign p = p_q_r;

endmodule
`default_nettype wire

[rtl/lennard_jones_pair_force_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Lennard-Jones pair force with minimum-image wrapping and a shifted potential.
// One pair displacement (Q10.22) enters per clock while the pipe advances and
// its force vector, shifted energy, virial (all Q24.24, saturated) and cutoff
// flag leave at the output; the latency is set by the bit-serial remainder
// stages of the box wrap, the 48-step reciprocal pipeline and five chained limb
// multipliers. The whole pipe advances whenever the output register is empty or
// being taken. Write the cell, cutoff and energy-shift registers only while no
// pair is in flight.
module lennard_jones_pair_force_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ljpf_pkg::COORD_W-1:0]   in_pair_dx,
  input  logic signed [ljpf_pkg::COORD_W-1:0]   in_pair_dy,
  input  logic signed [ljpf_pkg::COORD_W-1:0]   in_pair_dz,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ljpf_pkg::OUT_W-1:0]     out_force_x,
  output logic signed [ljpf_pkg::OUT_W-1:0]     out_force_y,
  output logic signed [ljpf_pkg::OUT_W-1:0]     out_force_z,
  output logic signed [ljpf_pkg::OUT_W-1:0]     out_pair_energy,
  output logic signed [ljpf_pkg::OUT_W-1:0]     out_pair_virial,
  output logic                                  out_within_cutoff,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ljpf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ljpf_pkg::*;

  logic [CELL_W-1:0] cell_x_r, cell_y_r, cell_z_r;
  logic [CUT_W-1:0]  cutoff_r;
  logic [OUT_W-1:0]  e_shift_r;

  logic                adv;
  logic [PIPE_LAT:1]   v_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_x_r  <= RST_CELL;
      cell_y_r  <= RST_CELL;
      cell_z_r  <= RST_CELL;
      cutoff_r  <= RST_CUTOFF_SQ;
      e_shift_r <= RST_E_SHIFT;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CELL_X:       cell_x_r  <= cfg_data[CELL_W-1:0];
        CFG_CELL_Y:       cell_y_r  <= cfg_data[CELL_W-1:0];
        CFG_CELL_Z:       cell_z_r  <= cfg_data[CELL_W-1:0];
        CFG_CUTOFF_SQ:    cutoff_r  <= cfg_data[CUT_W-1:0];
        CFG_ENERGY_SHIFT: e_shift_r <= cfg_data[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless a finished result is held
  assign adv       = out_ready || !v_r[PIPE_LAT];
  assign in_ready  = adv;
  assign out_valid = v_r[PIPE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[PIPE_LAT-1:1], in_valid};
  end

  // ---------------- minimum-image wrap
  logic signed [COORD_W-1:0] w [0:2];

  ljpf_wrap u_wrap_x (.clk(clk), .en(adv), .d(in_pair_dx), .cell_len(cell_x_r), .w(w[0]));
  ljpf_wrap u_wrap_y (.clk(clk), .en(adv), .d(in_pair_dy), .cell_len(cell_y_r), .w(w[1]));
  ljpf_wrap u_wrap_z (.clk(clk), .en(adv), .d(in_pair_dz), .cell_len(cell_z_r), .w(w[2]));

  // ---------------- squared distance
  logic [COORD_W-1:0] aw_r   [0:2];
  lane_t [2:0]        lane_r;
  logic [D2_W-1:0]    sq_r   [0:2];
  logic [D2_W-1:0]    d2_r;
  logic               within_r, near_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        aw_r[k]        <= w[k][COORD_W-1] ? COORD_W'(-w[k]) : COORD_W'(w[k]);
        lane_r[k].neg  <= w[k][COORD_W-1];
        lane_r[k].zero <= (w[k] == '0);
        sq_r[k]        <= D2_W'(aw_r[k]) * D2_W'(aw_r[k]);
      end
      d2_r     <= sq_r[0] + sq_r[1] + sq_r[2];
      within_r <= d2_r <= {10'b0, cutoff_r, 22'b0};
      near_r   <= d2_r < NEAR_LIMIT;
    end
  end

  // ---------------- inverse powers
  logic [INV2_W-1:0]  inv2;
  logic [MUL_P_W-1:0] p1, p2, p3, p4, p5;
  logic [52:0]        inv4;
  logic [58:0]        inv6;
  logic [64:0]        inv8;
  logic [76:0]        inv12;
  logic [88:0]        inv14;
  logic [INV2_W-1:0]  inv2_d_r [1:12];
  logic [58:0]        inv6_d_r [1:4];
  logic [64:0]        inv8_d_r [1:8];

  ljpf_recip u_recip (.clk(clk), .en(adv), .d2(d2_r), .inv2(inv2));

  assign inv4  = p1[92:40];
  assign inv6  = p2[98:40];
  assign inv8  = p3[104:40];
  assign inv12 = p4[116:40];
  assign inv14 = p5[128:40];

  ljpf_mul u_mul_inv4 (.clk(clk), .en(adv), .a(MUL_A_W'(inv2)), .b(MUL_B_W'(inv2)), .p(p1));
  ljpf_mul u_mul_inv6 (.clk(clk), .en(adv), .a(MUL_A_W'(inv4)),
                       .b(MUL_B_W'(inv2_d_r[4])), .p(p2));
  ljpf_mul u_mul_inv8 (.clk(clk), .en(adv), .a(MUL_A_W'(inv4)), .b(MUL_B_W'(inv4)), .p(p3));
  ljpf_mul u_mul_inv12 (.clk(clk), .en(adv), .a(MUL_A_W'(inv6)), .b(MUL_B_W'(inv6)), .p(p4));
  ljpf_mul u_mul_inv14 (.clk(clk), .en(adv), .a(MUL_A_W'(inv12)),
                        .b(MUL_B_W'(inv2_d_r[12])), .p(p5));

  always_ff @(posedge clk) begin
    if (adv) begin
      inv2_d_r[1] <= inv2;
      for (int i = 2; i <= 12; i++) inv2_d_r[i] <= inv2_d_r[i-1];
      inv6_d_r[1] <= inv6;
      for (int i = 2; i <= 4; i++) inv6_d_r[i] <= inv6_d_r[i-1];
      inv8_d_r[1] <= inv8;
      for (int i = 2; i <= 8; i++) inv8_d_r[i] <= inv8_d_r[i-1];
    end
  end

  // ---------------- virial and energy
  logic [MUL_A_W-1:0] va_r, vb_r, vmag_r;
  logic               vneg_r;
  logic               eneg_r;
  logic [76:0]        emag_r;
  logic signed [51:0] ed_r;
  logic [OUT_W-1:0]   vir_r, eng_r;
  logic [76:0]        inv6x;
  logic [62:0]        em;
  logic [50:0]        mm;
  logic [52:0]        ee;
  logic [OUT_W-1:0]   eng_nxt;

  assign inv6x = 77'(inv6_d_r[4]);
  assign em    = emag_r[76:14];
  assign mm    = (em > ENERGY_CLAMP) ? ENERGY_CLAMP[50:0] : em[50:0];
  assign ee    = {ed_r[51], ed_r} - {{5{e_shift_r[OUT_W-1]}}, e_shift_r};

  always_comb begin
    if (ee[52:47] == 6'b000000 || ee[52:47] == 6'b111111) eng_nxt = ee[OUT_W-1:0];
    else if (ee[52]) eng_nxt = NEG_MIN;
    else eng_nxt = POS_MAX;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      va_r   <= (MUL_A_W'(inv12) << 5) + (MUL_A_W'(inv12) << 4);
      vb_r   <= (MUL_A_W'(inv6_d_r[4]) << 4) + (MUL_A_W'(inv6_d_r[4]) << 3);
      eneg_r <= inv12 < inv6x;
      emag_r <= (inv12 < inv6x) ? inv6x - inv12 : inv12 - inv6x;
      vneg_r <= va_r < vb_r;
      vmag_r <= (va_r < vb_r) ? vb_r - va_r : va_r - vb_r;
      ed_r   <= eneg_r ? -signed'({1'b0, mm}) : signed'({1'b0, mm});
      vir_r  <= sat48(vneg_r, 128'(vmag_r[MUL_A_W-1:16]));
      eng_r  <= eng_nxt;
    end
  end

  // ---------------- force factor and force components
  logic [MUL_A_W-1:0] ga_r, gb_r, gmag_r;
  logic               gneg_r;
  logic [MUL_P_W-1:0] fp [0:2];
  logic [COORD_W-1:0] aw_d_r [0:2][1:33];

  always_ff @(posedge clk) begin
    if (adv) begin
      ga_r   <= (MUL_A_W'(inv14) << 5) + (MUL_A_W'(inv14) << 4);
      gb_r   <= (MUL_A_W'(inv8_d_r[8]) << 4) + (MUL_A_W'(inv8_d_r[8]) << 3);
      gneg_r <= ga_r < gb_r;
      gmag_r <= (ga_r < gb_r) ? gb_r - ga_r : ga_r - gb_r;
      for (int k = 0; k < 3; k++) begin
        aw_d_r[k][1] <= aw_r[k];
        for (int i = 2; i <= 33; i++) aw_d_r[k][i] <= aw_d_r[k][i-1];
      end
    end
  end

  ljpf_mul u_mul_fx (.clk(clk), .en(adv), .a(gmag_r), .b(MUL_B_W'(aw_d_r[0][33])), .p(fp[0]));
  ljpf_mul u_mul_fy (.clk(clk), .en(adv), .a(gmag_r), .b(MUL_B_W'(aw_d_r[1][33])), .p(fp[1]));
  ljpf_mul u_mul_fz (.clk(clk), .en(adv), .a(gmag_r), .b(MUL_B_W'(aw_d_r[2][33])), .p(fp[2]));

  // ---------------- align side information with the force products
  lane_t [2:0]      lane_d_r [1:37];
  logic [1:0]       flag_d_r [1:34];
  logic             gneg_d_r [1:4];
  logic [OUT_W-1:0] vir_d_r  [1:7];
  logic [OUT_W-1:0] eng_d_r  [1:7];

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_d_r[1] <= lane_r;
      for (int i = 2; i <= 37; i++) lane_d_r[i] <= lane_d_r[i-1];
      flag_d_r[1] <= {within_r, near_r};
      for (int i = 2; i <= 34; i++) flag_d_r[i] <= flag_d_r[i-1];
      gneg_d_r[1] <= gneg_r;
      for (int i = 2; i <= 4; i++) gneg_d_r[i] <= gneg_d_r[i-1];
      vir_d_r[1] <= vir_r;
      eng_d_r[1] <= eng_r;
      for (int i = 2; i <= 7; i++) begin
        vir_d_r[i] <= vir_d_r[i-1];
        eng_d_r[i] <= eng_d_r[i-1];
      end
    end
  end

  // ---------------- output register
  logic [OUT_W-1:0] f_nxt [0:2];
  logic [OUT_W-1:0] e_nxt, vr_nxt;
  logic             wc_nxt;
  logic [OUT_W-1:0] f_r [0:2];
  logic [OUT_W-1:0] e_r, vr_r;
  logic             wc_r;

  always_comb begin
    wc_nxt = flag_d_r[34][1];
    e_nxt  = '0;
    vr_nxt = '0;
    for (int k = 0; k < 3; k++) f_nxt[k] = '0;
    if (flag_d_r[34][1]) begin
      if (flag_d_r[34][0]) begin
        // very close pair: pin energy, virial and nonzero force components at the limits
        e_nxt  = POS_MAX;
        vr_nxt = POS_MAX;
        for (int k = 0; k < 3; k++) begin
          if (lane_d_r[37][k].zero) f_nxt[k] = '0;
          else f_nxt[k] = lane_d_r[37][k].neg ? NEG_MIN : POS_MAX;
        end
      end else begin
        e_nxt  = eng_d_r[7];
        vr_nxt = vir_d_r[7];
        for (int k = 0; k < 3; k++) begin
          if (lane_d_r[37][k].zero) f_nxt[k] = '0;
          else f_nxt[k] = sat48(gneg_d_r[4] ^ lane_d_r[37][k].neg,
                                128'(fp[k][MUL_P_W-1:38]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) f_r[k] <= f_nxt[k];
      e_r  <= e_nxt;
      vr_r <= vr_nxt;
      wc_r <= wc_nxt;
    end
  end

  assign out_force_x       = signed'(f_r[0]);
  assign out_force_y       = signed'(f_r[1]);
  assign out_force_z       = signed'(f_r[2]);
  assign out_pair_energy   = signed'(e_r);
  assign out_pair_virial   = signed'(vr_r);
  assign out_within_cutoff = wc_r;

endmodule
`default_nettype wire
